FILE: rtl/csrs_pkg.sv
`timescale 1ns / 1ps

package csrs_pkg;

	localparam logic REQ_POLL  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [1:0] REG_STEP_COUNT     = 2'd0;
	localparam logic [1:0] REG_WRAP_ENABLE    = 2'd1;
	localparam logic [1:0] REG_PRESYNC_ENABLE = 2'd2;

	localparam logic [3:0]  HAT_MID       = 4'd8;
	localparam logic [7:0]  VENDOR_NORMAL = 8'd4;
	localparam logic [7:0]  VENDOR_DONE   = 8'd88;
	localparam logic [15:0] BTN_L         = 16'h0010;
	localparam logic [15:0] BTN_R         = 16'h0020;
	localparam logic [15:0] BTN_A         = 16'h0004;
	localparam logic [15:0] BTN_LCLICK    = 16'h0400;
	localparam logic [15:0] BTN_CAPTURE   = 16'h2000;

	localparam logic [3:0] CODE_L      = 4'd6;
	localparam logic [3:0] CODE_R      = 4'd7;
	localparam logic [3:0] CODE_LCLICK = 4'd8;

	localparam int PRE_LEN = 4;

	typedef struct packed {
		logic       req_type;
		logic [7:0] entry_index;
		logic [7:0] entry_code;
		logic [7:0] entry_repeat;
	} req_word_t;

	typedef struct packed {
		logic [15:0] button;
		logic [3:0]  hat;
		logic [7:0]  vendor_code;
	} rpt_word_t;

	typedef struct packed {
		logic        en;
		logic [7:0]  index;
		logic [15:0] data;
	} store_wr_t;

	function automatic logic [15:0] map_button(input logic [3:0] code);
		logic [15:0] btn;
		unique case (code)
			CODE_LCLICK: btn = BTN_LCLICK;
			CODE_L:      btn = BTN_L;
			CODE_R:      btn = BTN_R;
			default:     btn = {12'd0, code};
		endcase
		return btn;
	endfunction

	// sync preamble: wait, L+R, wait, A
	function automatic logic [15:0] pre_button(input logic [1:0] idx);
		logic [15:0] btn;
		unique case (idx)
			2'd1:    btn = BTN_L | BTN_R;
			2'd3:    btn = BTN_A;
			default: btn = 16'd0;
		endcase
		return btn;
	endfunction

	function automatic logic [7:0] pre_repeat(input logic [1:0] idx);
		logic [7:0] rep;
		unique case (idx)
			2'd0:    rep = 8'd4;
			2'd2:    rep = 8'd2;
			default: rep = 8'd1;
		endcase
		return rep;
	endfunction

endpackage

FILE: rtl/controller_script_report_sequencer.sv
`timescale 1ns / 1ps

// Scripted gamepad report sequencer.
// Request channel (req_valid/req_stall/req): req_type REQ_WRITE stores one script
// entry (code byte and repeat count) and gives no report; REQ_POLL gives one report.
// Report channel (rpt_valid/rpt_stall/rpt): button, hat and vendor_code per poll.
// Configuration (cfg_we/cfg_index/cfg_data): step count, wrap and preamble enable,
// to be written by the user only while no word is in flight; the block does not enforce this.
// A poll word passes the input register and then the report register before its report shows.
// Throughput: one word per cycle while reports are not stalled; the state update of one
// poll and the registered script read for the next step are done together, with write-first
// forwarding on the script memory port.
// Reset clears the play state and registers (preamble on, wrap off, empty script);
// the script memory keeps no reset value and must be written before it is played.
// When the receiver stalls, the report register holds its word and one more
// poll word waits in the input register; req_stall rises only then, and script
// writes keep draining while reports are stalled until a poll reaches that register.
module controller_script_report_sequencer #(
	parameter int SCRIPT_DEPTH = 256,
	parameter int ECHO_FRAMES  = 12,
	parameter int BLANK_FRAMES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  csrs_pkg::req_word_t req,
	output logic                rpt_valid,
	input  logic                rpt_stall,
	output csrs_pkg::rpt_word_t rpt,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [8:0]          cfg_data
);
	import csrs_pkg::*;

	localparam int AW = $clog2(SCRIPT_DEPTH);
	localparam int PW = $clog2(SCRIPT_DEPTH + 1);
	localparam int CW = (PW > 9) ? PW : 9;
	localparam int EW = (ECHO_FRAMES > 0) ? $clog2(ECHO_FRAMES + 1) : 1;
	localparam int BW = (BLANK_FRAMES > 0) ? $clog2(BLANK_FRAMES + 1) : 1;

	typedef enum logic [1:0] {
		PH_START,
		PH_PRE,
		PH_MAIN
	} phase_t;

	// configuration
	logic [8:0] step_count_q;
	logic       wrap_q;
	logic       presync_q;

	// input stage and report register
	logic      req_valid_s1;
	req_word_t req_s1;
	logic      rpt_valid_q;
	rpt_word_t rpt_q;
	logic      rpt_free;
	logic      s1_go;
	logic      poll_go;

	// play state
	phase_t        phase_q, phase_d, phase_eff;
	logic [PW-1:0] pos_q, pos_d, pos_next;
	logic [EW-1:0] echo_q, echo_d;
	logic [BW-1:0] blank_q, blank_d;
	logic [7:0]    rep_q, rep_d;
	logic [15:0]   lbtn_q, lbtn_d;
	logic [3:0]    lhat_q, lhat_d;
	rpt_word_t     rpt_d;

	// step fetch
	logic [CW-1:0] len_wide;
	logic [PW-1:0] len_sel;
	logic          at_end;
	logic [15:0]   mem_word;
	logic [15:0]   entry0;
	logic [15:0]   fetch_word;
	logic [15:0]   step_btn;
	logic [3:0]    step_hat;
	logic [7:0]    step_rep;
	store_wr_t     wr;

	assign rpt_free  = !rpt_valid_q || !rpt_stall;
	assign s1_go     = req_valid_s1 && (req_s1.req_type == REQ_WRITE || rpt_free);
	assign poll_go   = s1_go && req_s1.req_type == REQ_POLL;
	assign req_stall = req_valid_s1 && !s1_go;
	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

	assign wr.en    = s1_go && req_s1.req_type == REQ_WRITE;
	assign wr.index = req_s1.entry_index;
	assign wr.data  = {req_s1.entry_code, req_s1.entry_repeat};

	assign pos_next = poll_go ? pos_d : pos_q;

	csrs_script_store #(
		.DEPTH(SCRIPT_DEPTH)
	) u_store (
		.clk    (clk),
		.wr     (wr),
		.rd_addr(pos_next[AW-1:0]),
		.rd_data(mem_word),
		.entry0 (entry0)
	);

	always_comb begin
		phase_eff = phase_q;
		if (phase_q == PH_START) begin
			phase_eff = presync_q ? PH_PRE : PH_MAIN;
		end

		len_wide = (CW'(step_count_q) > CW'(SCRIPT_DEPTH)) ? CW'(SCRIPT_DEPTH)
			: CW'(step_count_q);
		len_sel  = (phase_eff == PH_PRE) ? PW'(PRE_LEN) : PW'(len_wide);
		at_end   = pos_q >= len_sel;

		// wrapping restarts at entry zero, kept in a shadow register
		fetch_word = at_end ? entry0 : mem_word;
		if (phase_eff == PH_PRE) begin
			step_btn = pre_button(pos_q[1:0]);
			step_hat = HAT_MID;
			step_rep = pre_repeat(pos_q[1:0]);
		end else begin
			step_btn = map_button(fetch_word[15:12]);
			step_hat = fetch_word[11:8];
			step_rep = fetch_word[7:0];
		end
		if (step_rep == 8'd0) begin
			step_rep = 8'd1;
		end

		phase_d = phase_eff;
		pos_d   = pos_q;
		echo_d  = echo_q;
		blank_d = blank_q;
		rep_d   = rep_q;
		lbtn_d  = lbtn_q;
		lhat_d  = lhat_q;
		rpt_d   = '{button: 16'd0, hat: HAT_MID, vendor_code: VENDOR_NORMAL};

		if (echo_q != '0) begin
			echo_d = echo_q - 1'b1;
			rpt_d  = '{button: lbtn_q, hat: lhat_q, vendor_code: VENDOR_NORMAL};
		end else if (blank_q != '0) begin
			blank_d = blank_q - 1'b1;
		end else if (rep_q != 8'd0) begin
			rep_d   = rep_q - 8'd1;
			echo_d  = EW'(ECHO_FRAMES);
			blank_d = BW'(BLANK_FRAMES);
			rpt_d   = '{button: lbtn_q, hat: lhat_q, vendor_code: VENDOR_NORMAL};
		end else if (at_end && phase_eff == PH_PRE) begin
			// preamble done: one blank frame, then the script from its start
			phase_d = PH_MAIN;
			pos_d   = '0;
		end else if (at_end && !(wrap_q && len_sel != '0)) begin
			pos_d = len_sel;
			rpt_d = '{button: BTN_CAPTURE, hat: HAT_MID, vendor_code: VENDOR_DONE};
		end else begin
			pos_d   = (at_end ? PW'(0) : pos_q) + PW'(1);
			rep_d   = step_rep - 8'd1;
			echo_d  = EW'(ECHO_FRAMES);
			blank_d = BW'(BLANK_FRAMES);
			lbtn_d  = step_btn;
			lhat_d  = step_hat;
			rpt_d   = '{button: step_btn, hat: step_hat, vendor_code: VENDOR_NORMAL};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= '0;
			wrap_q       <= 1'b0;
			presync_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_COUNT:     step_count_q <= cfg_data;
				REG_WRAP_ENABLE:    wrap_q       <= cfg_data[0];
				REG_PRESYNC_ENABLE: presync_q    <= cfg_data[0];
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_valid_s1 || s1_go) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			pos_q       <= '0;
			echo_q      <= '0;
			blank_q     <= '0;
			rep_q       <= '0;
			lbtn_q      <= '0;
			lhat_q      <= HAT_MID;
			rpt_valid_q <= 1'b0;
		end else begin
			if (poll_go) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				echo_q  <= echo_d;
				blank_q <= blank_d;
				rep_q   <= rep_d;
				lbtn_q  <= lbtn_d;
				lhat_q  <= lhat_d;
			end
			if (rpt_free) begin
				rpt_valid_q <= poll_go;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (poll_go) begin
			rpt_q <= rpt_d;
		end
	end

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		!req_valid_s1 |-> !req_stall)
		else $error("request stalled with empty input stage");

	a_poll_gives_report: assert property (@(posedge clk) disable iff (!arst_n)
		poll_go |=> rpt_valid)
		else $error("poll did not load the report register");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(SCRIPT_DEPTH))
		else $error("step position beyond script depth");

	a_start_is_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_START |-> (pos_q == '0 && echo_q == '0 && rep_q == 8'd0))
		else $error("counters not clear before playback starts");

endmodule

FILE: rtl/csrs_script_store.sv
`timescale 1ns / 1ps

module csrs_script_store #(
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  csrs_pkg::store_wr_t        wr,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [15:0]                rd_data,
	output logic [15:0]                entry0
);
	import csrs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int PW = $clog2(DEPTH + 1);
	localparam int IW = (PW > 8) ? PW : 8;

	logic [15:0]   mem [DEPTH];
	logic [15:0]   rd_data_q;
	logic [15:0]   entry0_q;
	logic          wr_hit;
	logic [AW-1:0] wr_addr;

	assign wr_hit  = wr.en && (IW'(wr.index) < IW'(DEPTH));
	assign wr_addr = AW'(wr.index);

	// write-first read: a word written this cycle is seen at the same address
	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[wr_addr] <= wr.data;
		end
		if (wr_hit && wr_addr == rd_addr) begin
			rd_data_q <= wr.data;
		end else begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_hit && wr_addr == '0) begin
			entry0_q <= wr.data;
		end
	end

	assign rd_data = rd_data_q;
	assign entry0  = entry0_q;

endmodule

FILE: sim/tb_controller_script_report_sequencer.sv
`timescale 1ns / 1ps

module tb_controller_script_report_sequencer;
	import csrs_pkg::*;

	localparam int SCRIPT_DEPTH = 256;
	localparam int ECHO_FRAMES  = 12;
	localparam int BLANK_FRAMES = 16;
	localparam int SETTLE       = 6;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 95;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum logic [1:0] {PLAY_IDLE, PLAY_SYNC, PLAY_SCRIPT} play_phase_t;

	class report_board;
		rpt_word_t   pending_reports[$];
		int unsigned errors;
		logic [8:0]  step_count;
		logic        wrap_on;
		logic        sync_on;
		play_phase_t phase;
		int unsigned next_step;
		int unsigned echoes_left;
		int unsigned blanks_left;
		int unsigned presses_left;
		logic [15:0] held_button;
		logic [3:0]  held_hat;
		logic [15:0] script [SCRIPT_DEPTH];

		function new();
			errors = 0;
			step_count = '0;
			wrap_on = 1'b0;
			sync_on = 1'b1;
			phase = PLAY_IDLE;
			rewind();
			held_button = '0;
			held_hat = HAT_MID;
			foreach (script[i]) script[i] = '0;
		endfunction

		function void rewind();
			next_step = 0;
			echoes_left = 0;
			blanks_left = 0;
			presses_left = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [8:0] data);
			case (idx)
				REG_STEP_COUNT:     step_count = data;
				REG_WRAP_ENABLE:    wrap_on = data[0];
				REG_PRESYNC_ENABLE: sync_on = data[0];
				default: ;
			endcase
		endfunction

		function void note_request(req_word_t w);
			rpt_word_t   r;
			int unsigned len;
			int unsigned pos;
			int unsigned presses;
			logic [15:0] entry;

			if (w.req_type == REQ_WRITE) begin
				script[w.entry_index] = {w.entry_code, w.entry_repeat};
				return;
			end
			if (phase == PLAY_IDLE) begin
				phase = sync_on ? PLAY_SYNC : PLAY_SCRIPT;
				rewind();
			end
			r.vendor_code = VENDOR_NORMAL;
			if (echoes_left > 0) begin
				echoes_left--;
				r.button = held_button;
				r.hat = held_hat;
			end else if (blanks_left > 0) begin
				blanks_left--;
				r.button = '0;
				r.hat = HAT_MID;
			end else if (presses_left > 0) begin
				presses_left--;
				echoes_left = ECHO_FRAMES;
				blanks_left = BLANK_FRAMES;
				r.button = held_button;
				r.hat = held_hat;
			end else begin
				if (phase == PLAY_SYNC)
					len = PRE_LEN;
				else
					len = (step_count > SCRIPT_DEPTH) ? SCRIPT_DEPTH : step_count;
				pos = next_step;
				if (pos >= len && phase == PLAY_SYNC) begin
					// sync done: one blank frame, then the script proper
					phase = PLAY_SCRIPT;
					rewind();
					r.button = '0;
					r.hat = HAT_MID;
				end else if (pos >= len && !(wrap_on && len > 0)) begin
					next_step = len;
					r = '{BTN_CAPTURE, HAT_MID, VENDOR_DONE};
				end else begin
					if (pos >= len) pos = 0;
					if (phase == PLAY_SYNC) begin
						r.hat = HAT_MID;
						case (pos % PRE_LEN)
							0: begin r.button = '0; presses = 4; end
							1: begin r.button = BTN_L | BTN_R; presses = 1; end
							2: begin r.button = '0; presses = 2; end
							default: begin r.button = BTN_A; presses = 1; end
						endcase
					end else begin
						entry = script[pos];
						r.hat = entry[11:8];
						presses = {24'd0, entry[7:0]};
						case (entry[15:12])
							CODE_LCLICK: r.button = BTN_LCLICK;
							CODE_L:      r.button = BTN_L;
							CODE_R:      r.button = BTN_R;
							default:     r.button = {12'd0, entry[15:12]};
						endcase
					end
					if (presses == 0) presses = 1;
					next_step = pos + 1;
					presses_left = presses - 1;
					echoes_left = ECHO_FRAMES;
					blanks_left = BLANK_FRAMES;
					held_button = r.button;
					held_hat = r.hat;
				end
			end
			pending_reports.push_back(r);
		endfunction

		function void check_report(rpt_word_t got);
			rpt_word_t want;

			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: report with none pending: %h", $time, got);
				return;
			end
			want = pending_reports.pop_front();
			if (got.button !== want.button) begin
				errors++;
				$display("%0t: button expected %h got %h", $time, want.button, got.button);
			end
			if (got.hat !== want.hat) begin
				errors++;
				$display("%0t: hat expected %h got %h", $time, want.hat, got.hat);
			end
			if (got.vendor_code !== want.vendor_code) begin
				errors++;
				$display("%0t: vendor_code expected %0d got %0d", $time,
					want.vendor_code, got.vendor_code);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_word_t   req;
	logic        rpt_valid;
	logic        rpt_stall;
	rpt_word_t   rpt;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;

	report_board sb;
	int unsigned cycles;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned fill_ptr;

	controller_script_report_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rpt_valid(rpt_valid),
		.rpt_stall(rpt_stall),
		.rpt(rpt),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("controller_script_report_sequencer: mismatch");
			$finish;
		end
	end

	always @(negedge clk) begin
		rpt_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rpt_valid && !rpt_stall)
			sb.check_report(rpt);
	end

	task automatic send_word(input req_word_t w);
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(w);
		@(negedge clk);
	endtask

	task automatic send_entry(input logic [7:0] idx, input logic [7:0] code,
			input logic [7:0] presses);
		send_word('{REQ_WRITE, idx, code, presses});
	endtask

	task automatic send_poll();
		req_word_t w;

		w.req_type = REQ_POLL;
		w.entry_index = 8'($urandom);
		w.entry_code = 8'($urandom);
		w.entry_repeat = 8'($urandom);
		send_word(w);
	endtask

	task automatic send_random();
		int unsigned idx;
		logic        do_write;

		do_write = 1'b0;
		if (fill_ptr < SCRIPT_DEPTH && $urandom_range(99) < 50) begin
			idx = fill_ptr;
			fill_ptr++;
			do_write = 1'b1;
		end else if ($urandom_range(99) < 10) begin
			idx = $urandom_range(SCRIPT_DEPTH - 1);
			do_write = 1'b1;
		end
		// long press counts only where playback rarely gets to
		if (do_write)
			send_entry(8'(idx), 8'($urandom),
				(idx < 64) ? 8'($urandom_range(2)) : 8'($urandom));
		else
			send_poll();
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending_reports.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		logic [8:0] steps;
		logic       wrap;

		sb = new();
		cycles = 0;
		fill_ptr = 8;
		gap_pct = 24;
		stall_pct = 68;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rpt_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_STEP_COUNT;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_reg(REG_PRESYNC_ENABLE, 9'd0);
		write_reg(REG_PRESYNC_ENABLE, 9'd1);
		write_reg(REG_WRAP_ENABLE, 9'd1);
		write_reg(REG_STEP_COUNT, 9'd4);
		cfg_we <= 1'b0;

		// left-click with zero presses, L/R remaps, raw codes, hat extremes
		send_entry(8'd0, 8'h8F, 8'd0);
		send_entry(8'd1, 8'h60, 8'd1);
		send_entry(8'd2, 8'h78, 8'd2);
		send_entry(8'd3, 8'hF3, 8'd1);
		send_entry(8'd4, 8'h00, 8'd1);
		send_entry(8'd5, 8'h52, 8'd0);
		send_entry(8'd6, 8'h9A, 8'd1);
		send_entry(8'd7, 8'h1C, 8'd2);
		send_entry(8'd255, 8'hFF, 8'hFF);
		send_entry(8'd128, 8'hA5, 8'h5A);
		send_word('{REQ_POLL, 8'hFF, 8'hFF, 8'hFF});
		send_word('{REQ_POLL, 8'h00, 8'h00, 8'h00});
		repeat (6) send_poll();

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				6: begin steps = 9'd0; wrap = 1'b1; end
				9: begin steps = 9'd0; wrap = 1'b0; end
				7, 10: begin
					steps = (fill_ptr >= SCRIPT_DEPTH) ? 9'(SCRIPT_DEPTH) : 9'(fill_ptr);
					wrap = 1'($urandom_range(1));
				end
				default: begin
					steps = 9'($urandom_range(6, 1));
					wrap = 1'($urandom_range(1));
				end
			endcase
			write_reg(REG_STEP_COUNT, steps);
			write_reg(REG_WRAP_ENABLE, {8'd0, wrap});
			write_reg(REG_PRESYNC_ENABLE, {8'd0, 1'($urandom_range(1))});
			cfg_we <= 1'b0;
			if (p < PHASES / 3) begin
				gap_pct = 24;
				stall_pct = 68;
			end else if (p < 2 * PHASES / 3) begin
				gap_pct = 68;
				stall_pct = 24;
			end else begin
				gap_pct = 0;
				stall_pct = 0;
			end
			repeat (PHASE_ITEMS) send_random();
		end

		drain();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending_reports.size() == 0)
			$display("controller_script_report_sequencer: match");
		else
			$display("controller_script_report_sequencer: mismatch");
		$finish;
	end

endmodule
